// ----- rtl/fsb_pkg.sv -----
// Shared types, constants and the coefficient ROM for the selectable-bank FIR filter.
// Used by fsb_ring, fsb_mac and fir_filter_selectable_bank_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fsb_pkg;

  // Ring depth and the index and count widths that follow from it.
  localparam int MAX_TAPS  = 32;
  localparam int IDX_W     = $clog2(MAX_TAPS);
  localparam int CNT_W     = $clog2(MAX_TAPS + 1);

  // Fixed field and datapath widths.
  localparam int SAMPLE_W  = 16;
  localparam int PROD_W    = 2 * SAMPLE_W;
  localparam int ACC_W     = 40;
  localparam int FRAC_W    = 15;
  localparam int BANK_W    = 2;
  localparam int TAPS_W    = 6;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;

  // Coefficient ROM shape.
  localparam int NUM_BANKS = 3;
  localparam int BANK_TAPS = 31;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BANK_SELECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = 2'd1;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_WRITE,
    S_ISSUE,
    S_DRAIN
  } seq_state_e;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clr;  // clear the accumulator for a new sample
    logic en;   // operands on the inputs are valid this cycle
  } mac_ctl_t;

  // Q1.15 coefficients: bandpass, Hilbert phase shifter, lowpass.
  localparam int COEF_ROM [NUM_BANKS][BANK_TAPS] = '{
    '{ -69, -102, -138, -134, -36, 203, 554, 947,
       1275, 1425, 1311, 885, 157, -760, -1655, -2330,
       -2638, -2487, -1878, -914, 180, 1137, 1779, 1996,
       1753, 1144, 344, -410, -898, -1068, -931 },
    '{ -1389, 0, -1622, 0, -1946, 0, -2431, 0,
       -3244, 0, -4866, 0, -9735, 0, -29206, 0,
       29206, 0, 9735, 0, 4866, 0, 3244, 0,
       2431, 0, 1946, 0, 1622, 0, 1389 },
    '{ 72, 128, 226, 370, 560, 793, 1052, 1324,
       1596, 1845, 2051, 2205, 2297, 2327, 2336, 2336,
       2336, 2327, 2297, 2205, 2051, 1845, 1596, 1324,
       1052, 793, 560, 370, 226, 128, 72 }
  };

  // Coefficient lookup; an unused bank or a tap past the bank reads as zero.
  function automatic logic signed [SAMPLE_W-1:0] coef_at(
    input logic [BANK_W-1:0] bank,
    input logic [IDX_W-1:0]  tap
  );
    logic signed [SAMPLE_W-1:0] c;
    c = '0;
    if ((int'(bank) < NUM_BANKS) && (int'(tap) < BANK_TAPS)) begin
      c = SAMPLE_W'(COEF_ROM[bank][tap]);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/fir_filter_selectable_bank_core.sv -----
// Selectable-bank FIR filter: one shared multiply-accumulate walked over the ring per sample.
// Each sample is written to the ring, then its n taps go through the shared MAC one tap per cycle,
// n the effective tap count (1..32); the sum drains before the result is loaded and the sequencer
// returns to idle, so a new input is accepted only after the current result is loaded.
// The output register lets the next input transfer happen while a result waits to be taken.
// Reset (rst_ni low, asynchronous) clears the ring, the position, bank 0 and tap count 31.
// Depends on fsb_pkg, fsb_ring and fsb_mac.
`timescale 1ns / 1ps
`default_nettype none

module fir_filter_selectable_bank_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration write port.
  input  wire logic                              cfg_we_i,
  input  wire logic [fsb_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [fsb_pkg::CFG_W-1:0]         cfg_data_i,
  // Input stream.
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [15:0]                       s_axis_tdata,  // [15:0] sample_in
  // Output stream.
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [15:0]                            m_axis_tdata   // [15:0] sample_out
);

  localparam int IDX_W = fsb_pkg::IDX_W;
  localparam int CNT_W = fsb_pkg::CNT_W;

  fsb_pkg::seq_state_e                   state_q, state_d;
  logic [fsb_pkg::BANK_W-1:0]            bank_q;
  logic [fsb_pkg::TAPS_W-1:0]            taps_q;
  logic [IDX_W-1:0]                      wpos_q;
  logic [CNT_W-1:0]                      n_q;
  logic [IDX_W-1:0]                      pos_q;
  logic [IDX_W-1:0]                      idx_q;
  logic [IDX_W-1:0]                      tap_q;
  logic signed [fsb_pkg::SAMPLE_W-1:0]   smp_q;
  logic signed [fsb_pkg::SAMPLE_W-1:0]   coef_q;
  logic                                  iss_q;
  logic                                  out_vld_q;
  logic [15:0]                           out_data_q;

  logic [CNT_W-1:0]                      n_eff;
  logic [CNT_W-1:0]                      pos_inc;
  logic                                  in_xfer;
  logic                                  last_tap;
  logic                                  load_out;
  logic                                  ring_we;
  logic signed [fsb_pkg::SAMPLE_W-1:0]   ring_rdata;
  logic                                  mac_busy;
  logic signed [fsb_pkg::SAMPLE_W-1:0]   mac_res;
  fsb_pkg::mac_ctl_t                     mac_ctl;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= '0;
      taps_q <= fsb_pkg::TAPS_W'(31);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fsb_pkg::REG_BANK_SELECT: bank_q <= cfg_data_i[fsb_pkg::BANK_W-1:0];
        fsb_pkg::REG_TAP_COUNT:   taps_q <= cfg_data_i[fsb_pkg::TAPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective tap count: zero acts as one, large values clamp to the ring depth.
  always_comb begin
    if (taps_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(taps_q) > fsb_pkg::MAX_TAPS) begin
      n_eff = CNT_W'(fsb_pkg::MAX_TAPS);
    end else begin
      n_eff = CNT_W'(taps_q);
    end
  end

  assign in_xfer  = s_axis_tvalid & s_axis_tready;
  assign last_tap = (CNT_W'(tap_q) == (n_q - CNT_W'(1)));
  assign pos_inc  = CNT_W'(pos_q) + CNT_W'(1);
  assign load_out = (state_q == fsb_pkg::S_DRAIN) && !iss_q && !mac_busy &&
                    (!out_vld_q || m_axis_tready);

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fsb_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and control outputs.
  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    ring_we       = 1'b0;
    mac_ctl.clr   = 1'b0;
    mac_ctl.en    = iss_q;
    case (state_q)
      fsb_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_d = fsb_pkg::S_WRITE;
        end
      end
      fsb_pkg::S_WRITE: begin
        ring_we     = 1'b1;
        mac_ctl.clr = 1'b1;
        state_d     = fsb_pkg::S_ISSUE;
      end
      fsb_pkg::S_ISSUE: begin
        if (last_tap) begin
          state_d = fsb_pkg::S_DRAIN;
        end
      end
      fsb_pkg::S_DRAIN: begin
        if (load_out) begin
          state_d = fsb_pkg::S_IDLE;
        end
      end
      default: state_d = fsb_pkg::S_IDLE;
    endcase
  end

  // Write position; it wraps at the tap count of the current sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q <= '0;
    end else if (state_q == fsb_pkg::S_WRITE) begin
      wpos_q <= (pos_inc >= n_q) ? '0 : pos_inc[IDX_W-1:0];
    end
  end

  // Issue-stage valid bit that feeds the MAC in the cycle after the ring read is issued.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q <= 1'b0;
    end else begin
      iss_q <= (state_q == fsb_pkg::S_ISSUE);
    end
  end

  // Per-sample working registers: latch on transfer, then walk newest to oldest.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      smp_q <= s_axis_tdata;
      n_q   <= n_eff;
      pos_q <= (CNT_W'(wpos_q) >= n_eff) ? '0 : wpos_q;
    end
    if (state_q == fsb_pkg::S_WRITE) begin
      idx_q <= pos_q;
      tap_q <= '0;
    end else if (state_q == fsb_pkg::S_ISSUE) begin
      tap_q <= tap_q + IDX_W'(1);
      if (idx_q == '0) begin
        idx_q <= IDX_W'(n_q - CNT_W'(1));
      end else begin
        idx_q <= idx_q - IDX_W'(1);
      end
    end
    coef_q <= fsb_pkg::coef_at(bank_q, tap_q);
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= mac_res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  fsb_ring u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (ring_we),
    .waddr_i (pos_q),
    .wdata_i (smp_q),
    .raddr_i (idx_q),
    .rdata_o (ring_rdata)
  );

  fsb_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (mac_ctl),
    .coef_i  (coef_q),
    .smp_i   (ring_rdata),
    .busy_o  (mac_busy),
    .res_o   (mac_res)
  );

`ifndef SYNTH
  // An input transfer always starts the ring write in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == fsb_pkg::S_WRITE))
    else $error("input transfer did not start a ring write");

  // The tap walk stays inside the ring of the current sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fsb_pkg::S_ISSUE) |-> ((CNT_W'(idx_q) < n_q) && (CNT_W'(tap_q) < n_q)))
    else $error("tap walk left the ring");

  // The MAC is fed only in the cycle after a ring read was issued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_ctl.en |-> ($past(state_q) == fsb_pkg::S_ISSUE))
    else $error("MAC enabled without an issued tap");

  // A result is loaded only once the accumulator has settled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!mac_ctl.en && !$past(mac_ctl.en)))
    else $error("result loaded before the accumulator settled");
`endif

endmodule

`default_nettype wire

// ----- rtl/fsb_ring.sv -----
// Circular sample store: one write port and one registered read port, cleared at reset.
// Depends on fsb_pkg for the depth and sample width.
`timescale 1ns / 1ps
`default_nettype none

module fsb_ring (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 we_i,
  input  wire logic [fsb_pkg::IDX_W-1:0]            waddr_i,
  input  wire logic signed [fsb_pkg::SAMPLE_W-1:0]  wdata_i,
  input  wire logic [fsb_pkg::IDX_W-1:0]            raddr_i,
  output logic signed [fsb_pkg::SAMPLE_W-1:0]       rdata_o
);

  logic signed [fsb_pkg::SAMPLE_W-1:0] ring_q [fsb_pkg::MAX_TAPS];
  logic signed [fsb_pkg::SAMPLE_W-1:0] rdata_q;

  // Sample storage, all zero after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fsb_pkg::MAX_TAPS; i++) begin
        ring_q[i] <= '0;
      end
    end else if (we_i) begin
      ring_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read.
  always_ff @(posedge clk_i) begin
    rdata_q <= ring_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/fsb_mac.sv -----
// Shared multiply-accumulate unit with rounding, scaling and saturation of the sum.
// Depends on fsb_pkg for widths and the mac_ctl_t control struct.
`timescale 1ns / 1ps
`default_nettype none

module fsb_mac (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire fsb_pkg::mac_ctl_t                    ctl_i,
  input  wire logic signed [fsb_pkg::SAMPLE_W-1:0]  coef_i,
  input  wire logic signed [fsb_pkg::SAMPLE_W-1:0]  smp_i,
  output logic                                      busy_o,
  output logic signed [fsb_pkg::SAMPLE_W-1:0]       res_o
);

  localparam int SHIFT_W = fsb_pkg::ACC_W - fsb_pkg::FRAC_W;

  logic signed [fsb_pkg::PROD_W-1:0]  prod_q;
  logic                               prod_vld_q;
  logic signed [fsb_pkg::ACC_W-1:0]   acc_q;
  logic signed [fsb_pkg::ACC_W-1:0]   rnd;
  logic signed [SHIFT_W-1:0]          scaled;

  // Product stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctl_i.en;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= fsb_pkg::PROD_W'(coef_i * smp_i);
  end

  // Accumulator stage; the product is sign-extended to the accumulator width.
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + {{(fsb_pkg::ACC_W - fsb_pkg::PROD_W){prod_q[fsb_pkg::PROD_W-1]}}, prod_q};
    end
  end

  // Round half up, floor shift by the fraction width and saturate to a sample.
  always_comb begin
    rnd    = acc_q + fsb_pkg::ACC_W'(1 << (fsb_pkg::FRAC_W - 1));
    scaled = SHIFT_W'(rnd >>> fsb_pkg::FRAC_W);
    if (scaled > SHIFT_W'(32767)) begin
      res_o = 16'sh7fff;
    end else if (scaled < -SHIFT_W'(32768)) begin
      res_o = 16'sh8000;
    end else begin
      res_o = fsb_pkg::SAMPLE_W'(scaled);
    end
  end

  assign busy_o = ctl_i.en | prod_vld_q;

endmodule

`default_nettype wire
